/* src/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

   localparam int WordBits = 32;
   localparam int StepBits = 8;           // quotient bits resolved per cycle

   localparam logic [4:0] RadixDec  = 5'd10;
   localparam logic [4:0] RadixHex  = 5'd16;
   localparam logic [6:0] CharZero  = 7'h30;   // '0'
   localparam logic [6:0] CharAlpha = 7'h37;   // 'A' - 10
   localparam logic [6:0] CharMinus = 7'h2d;   // '-'

   typedef struct packed {
      logic signed [31:0] value;
      logic               hex_mode;
   } req_type;

   typedef struct packed {
      logic [6:0] character;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic sign_put;
      logic digit_put;
   } dp_cmd_type;

   typedef struct packed {
      logic pass_last;
      logic quot_zero;
      logic negative;
      logic idx_zero;
      logic out_free;
   } dp_stat_type;

   function automatic logic [6:0] digit_char(input logic [3:0] digit);
      logic [6:0] code;
      if (digit < 4'd10) begin
         code = CharZero + 7'(digit);
      end else begin
         code = CharAlpha + 7'(digit);
      end
      return code;
   endfunction

endpackage

`default_nettype wire

/* src/itoa_ctrl.sv */
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: load, digit extraction passes, sign and digit output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire itoa_pkg::dp_stat_type stat,
   output itoa_pkg::dp_cmd_type       cmd
);

   itoa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itoa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itoa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = itoa_pkg::ST_DIVIDE;
            end
         end
         itoa_pkg::ST_DIVIDE: begin
            if (stat.pass_last && stat.quot_zero) begin
               state_in = stat.negative ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
            end
         end
         itoa_pkg::ST_SIGN: begin
            if (stat.out_free) begin
               state_in = itoa_pkg::ST_EMIT;
            end
         end
         itoa_pkg::ST_EMIT: begin
            if (stat.out_free && stat.idx_zero) begin
               state_in = itoa_pkg::ST_IDLE;
            end
         end
         default: state_in = itoa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         itoa_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         itoa_pkg::ST_DIVIDE: cmd.div_step  = 1'b1;
         itoa_pkg::ST_SIGN:   cmd.sign_put  = stat.out_free;
         itoa_pkg::ST_EMIT:   cmd.digit_put = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

/* src/itoa_datapath.sv */
// ----------------------------------------------------------------------------
// itoa_datapath
// Magnitude register, radix divider, digit store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_datapath #(
   parameter int WORD_BITS = itoa_pkg::WordBits
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire itoa_pkg::req_type    req_data,
   input  wire itoa_pkg::dp_cmd_type cmd,
   output itoa_pkg::dp_stat_type     stat,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output itoa_pkg::rsp_type         rsp_data
);

   localparam int StepBits   = itoa_pkg::StepBits;
   localparam int MagBits    = ((WORD_BITS + StepBits - 1) / StepBits) * StepBits;
   localparam int Passes     = MagBits / StepBits;
   localparam int PassBits   = $clog2(Passes + 1);
   localparam int DigitDepth = WORD_BITS / 3 + 1;
   localparam int IdxBits    = $clog2(DigitDepth);
   localparam int CntBits    = $clog2(DigitDepth + 1);

   logic [WORD_BITS+31:0] wide;
   logic [WORD_BITS-1:0]  word;
   logic [WORD_BITS-1:0]  mag;
   logic                  negative;

   logic [MagBits-1:0]    mag_ff, mag_in;
   logic [3:0]            rem_ff, rem_in;
   logic [PassBits-1:0]   pass_ff;
   logic [4:0]            radix_ff;
   logic                  neg_ff;
   logic [CntBits-1:0]    cnt_ff;
   logic [3:0]            digits_ff [DigitDepth];
   logic                  rsp_valid_ff;
   itoa_pkg::rsp_type     rsp_data_ff;

   logic [StepBits-1:0]   quot;
   logic [4:0]            trial;
   logic [IdxBits-1:0]    rd_idx;
   logic                  pass_last;
   logic                  out_free;

   assign wide     = {WORD_BITS'(0), req_data.value};
   assign word     = wide[WORD_BITS-1:0];
   assign negative = word[WORD_BITS-1];
   assign mag      = negative ? (~word + 1'b1) : word;

   // restoring division, StepBits quotient bits per pass, MSB first
   always_comb begin
      rem_in = rem_ff;
      quot   = '0;
      trial  = '0;
      for (int i = 0; i < StepBits; i++) begin
         trial = {rem_in, mag_ff[MagBits-1-i]};
         if (trial >= radix_ff) begin
            quot[StepBits-1-i] = 1'b1;
            rem_in             = 4'(trial - radix_ff);
         end else begin
            rem_in = trial[3:0];
         end
      end
      mag_in = (mag_ff << StepBits) | MagBits'(quot);
   end

   assign pass_last = (pass_ff == PassBits'(Passes - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_idx    = IdxBits'(cnt_ff - 1'b1);

   assign stat.pass_last = pass_last;
   assign stat.quot_zero = (mag_in == '0);
   assign stat.negative  = neg_ff;
   assign stat.idx_zero  = (cnt_ff == CntBits'(1));
   assign stat.out_free  = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pass_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         if (cmd.sign_put || cmd.digit_put) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load) begin
            pass_ff <= '0;
            cnt_ff  <= '0;
         end else if (cmd.div_step) begin
            if (pass_last) begin
               pass_ff <= '0;
               cnt_ff  <= cnt_ff + 1'b1;
            end else begin
               pass_ff <= pass_ff + 1'b1;
            end
         end else if (cmd.digit_put) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff   <= MagBits'(mag);
         rem_ff   <= '0;
         radix_ff <= req_data.hex_mode ? itoa_pkg::RadixHex : itoa_pkg::RadixDec;
         neg_ff   <= negative;
      end else if (cmd.div_step) begin
         mag_ff <= mag_in;
         rem_ff <= pass_last ? 4'd0 : rem_in;
         if (pass_last) begin
            digits_ff[cnt_ff[IdxBits-1:0]] <= rem_in;
         end
      end
      if (cmd.sign_put) begin
         rsp_data_ff.character <= itoa_pkg::CharMinus;
         rsp_data_ff.last      <= 1'b0;
      end else if (cmd.digit_put) begin
         rsp_data_ff.character <= itoa_pkg::digit_char(digits_ff[rd_idx]);
         rsp_data_ff.last      <= (cnt_ff == CntBits'(1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_put_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.sign_put || cmd.digit_put) |-> out_free)
      else $error("output beat written over an untaken beat");

   a_digit_present: assert property (@(posedge clock) disable iff (reset)
      cmd.digit_put |-> (cnt_ff != '0))
      else $error("digit beat with empty digit store");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < radix_ff))
      else $error("partial remainder not below radix");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.digit_put && cnt_ff == CntBits'(1)) |=> (cnt_ff == '0))
      else $error("digit store not drained after last beat");

endmodule

`default_nettype wire

/* src/integer_to_ascii_core.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_core
// Signed integer to decimal or upper-case hex ASCII text, one character per
// beat, most significant first, sign as a leading '-'.
// ----------------------------------------------------------------------------
//   channel  direction  payload             handshake
//   req      in         value, hex_mode     req_valid / req_stall
//   rsp      out        character, last     rsp_valid / rsp_stall
//
// One item at a time. Each digit is the remainder of a division by the radix
// in the shared divider (8 quotient bits a cycle); then comes one beat per
// character. Reset clears the sequencer, the counters and the output valid.
// rsp_stall holds the output register and pauses the character sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_core #(
   parameter int WORD_BITS = itoa_pkg::WordBits
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire itoa_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output itoa_pkg::rsp_type      rsp_data
);

   itoa_pkg::dp_cmd_type  cmd;
   itoa_pkg::dp_stat_type stat;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   itoa_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for integer_to_ascii_core. Drives signed integers in
// decimal and hex mode, predicts the character beats of each number and
// checks every accepted result beat against them in order. Random stalls on
// both channels, a calm stretch, a long result hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int         WORD_BITS     = 32;
   localparam int         NUM_RANDOM    = 100;
   localparam int         IDLE_PERCENT  = 37;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         SETTLE_CYCLES = 100;
   localparam logic [4:0] BASE_DEC      = 5'd10;
   localparam logic [4:0] BASE_HEX      = 5'd16;
   localparam logic [6:0] ASCII_ZERO    = 7'h30;
   localparam logic [6:0] ASCII_LETTER  = 7'h37;   // 'A' - 10
   localparam logic [6:0] ASCII_MINUS   = 7'h2d;

   class text_scoreboard;
      itoa_pkg::rsp_type expected_chars[$];
      int      error_count = 0;
      int      beat_count  = 0;

      task report(string what);
         $display("ERROR @%0t: %s", $time, what);
         error_count++;
      endtask

      function int pending();
         return expected_chars.size();
      endfunction

      // work out the text of one accepted number
      function void note_number(itoa_pkg::req_type item);
         logic [WORD_BITS-1:0] word;
         logic [WORD_BITS-1:0] mag;
         logic [4:0]           base;
         logic [3:0]           digit;
         logic [6:0]           digits[$];
         itoa_pkg::rsp_type    beat;
         word  = item.value[WORD_BITS-1:0];
         mag   = word[WORD_BITS-1] ? -word : word;
         base  = item.hex_mode ? BASE_HEX : BASE_DEC;
         do begin
            digit = 4'(mag % base);
            digits.push_front(digit < 4'd10 ? ASCII_ZERO + 7'(digit)
                                            : ASCII_LETTER + 7'(digit));
            mag = mag / base;
         end while (mag != 0);
         if (word[WORD_BITS-1]) begin
            beat.character = ASCII_MINUS;
            beat.last      = 1'b0;
            expected_chars.push_back(beat);
         end
         foreach (digits[i]) begin
            beat.character = digits[i];
            beat.last      = (i == digits.size() - 1);
            expected_chars.push_back(beat);
         end
      endfunction

      task check_char(itoa_pkg::rsp_type got);
         itoa_pkg::rsp_type want;
         beat_count++;
         if (expected_chars.size() == 0) begin
            report($sformatf("beat %0d: unexpected character %h", beat_count,
                             got.character));
         end else begin
            want = expected_chars.pop_front();
            if (got.character !== want.character)
               report($sformatf("beat %0d: character %h, expected %h", beat_count,
                                got.character, want.character));
            if (got.last !== want.last)
               report($sformatf("beat %0d: last %b, expected %b", beat_count,
                                got.last, want.last));
         end
      endtask
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   itoa_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   itoa_pkg::rsp_type rsp_data;

   text_scoreboard sb = new();
   bit calm          = 1'b0;
   int hold_requests = 0;
   int hold_served   = 0;

   integer_to_ascii_core #(
      .WORD_BITS(WORD_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // receiver: random stalls, none while calm, long hold-off on request
   initial begin
      int left;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            rsp_stall = 1'b1;
            for (left = HOLD_CYCLES; left > 1; left--) @(negedge clock);
            hold_served++;
         end else if (calm) begin
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_char(rsp_data);
   end

   // called just after a falling edge; returns just after a falling edge
   task send_number(logic signed [31:0] value, logic hex_mode);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_data.value    = value;
      req_data.hex_mode = hex_mode;
      do @(posedge clock); while (req_stall);
      sb.note_number(req_data);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] v;
      int          k;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = 32'($urandom_range(200)) - 32'd100;
         2: begin
            k = $urandom_range(31);
            v = (32'd1 << k) + 32'($urandom_range(4)) - 32'd2;
            if ($urandom_range(1)) v = -v;
         end
         default: v = {1'b1, 31'($urandom)};
      endcase
      return v;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_number(32'sd0, 1'b0);
      send_number(32'sd0, 1'b1);
      send_number(32'sd1, 1'b0);
      send_number(-32'sd1, 1'b0);
      send_number(-32'sd1, 1'b1);
      send_number(32'sh7fffffff, 1'b0);
      send_number(32'sh7fffffff, 1'b1);
      send_number(32'sh80000000, 1'b0);
      send_number(32'sh80000000, 1'b1);
      send_number(32'sd9, 1'b0);
      send_number(32'sd10, 1'b0);
      send_number(32'sd15, 1'b1);
      send_number(32'sd16, 1'b1);
      send_number(-32'sd10, 1'b0);
      send_number(32'shdeadbeef, 1'b1);
      send_number(32'sd1000000000, 1'b0);
      send_number(-32'sd999999999, 1'b0);
      send_number(32'shfffffff0, 1'b1);
      send_number(32'sh0abcdef9, 1'b1);
      send_number(32'sh55555555, 1'b0);
      wait_drained();

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 20) hold_requests++;
         if (n == 50) calm = 1'b1;
         if (n == 80) calm = 1'b0;
         if (n == 95) wait_drained();
         send_number(random_value(), 1'($urandom_range(1)));
      end

      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/itoa_pkg.sv
src/itoa_ctrl.sv
src/itoa_datapath.sv
src/integer_to_ascii_core.sv
dv/tb.sv
